/* hdl/gcs_pkg.sv */
// Glyph column segmenter package: result record, handshake slot type,
// register indexes and field widths. No dependencies.
`timescale 1ns / 1ps

package gcs_pkg;

  localparam int ALPHA_W    = 8;
  localparam int EXPECT_W   = 9;
  localparam int ORDINAL_W  = 10;
  localparam int START_W    = 10;
  localparam int WIDTH_W    = 11;
  localparam int COUNT_W    = 11;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_INDEX_W-1:0] REG_INK_LEVEL       = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_GLYPHS = 1'b1;

  localparam logic KIND_GLYPH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [COUNT_W-1:0]   COUNT_MAX   = '1;
  localparam logic [ORDINAL_W-1:0] ORDINAL_MAX = '1;

  typedef struct packed {
    logic                 kind;
    logic [ORDINAL_W-1:0] glyph_ordinal;
    logic [START_W-1:0]   start_column;
    logic [WIDTH_W-1:0]   glyph_width;
    logic                 unmapped;
    logic [COUNT_W-1:0]   glyph_total;
    logic                 count_mismatch;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } result_slot_t;

endpackage

/* hdl/glyph_column_segmenter_unit.sv */
// Glyph column segmenter top level: column profile tracker feeding a result
// queue. Depends on gcs_pkg, gcs_profile, gcs_result_fifo.
//
//   channel  handshake             payload
//   in       in_valid / in_ready   alpha, column_end, image_end
//   out      out_valid / out_ready kind, glyph_ordinal, start_column, glyph_width,
//                                  unmapped, glyph_total, count_mismatch, last
//   cfg      cfg_we                cfg_index, cfg_data
//
// One pixel per cycle while in_ready; results go through the input register, then
// the queue, and one result leaves per cycle while out_ready is high.
// A pixel at image end can queue two results; the four-entry queue holds
// input while fewer than two entries are free.
// Synchronous active-high reset clears run state, queue and registers.
`timescale 1ns / 1ps

module glyph_column_segmenter_unit #(
  parameter int MAX_COLUMNS = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [gcs_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [gcs_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [gcs_pkg::ALPHA_W-1:0]       alpha,
  input  logic                              column_end,
  input  logic                              image_end,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              kind,
  output logic [gcs_pkg::ORDINAL_W-1:0]     glyph_ordinal,
  output logic [gcs_pkg::START_W-1:0]       start_column,
  output logic [gcs_pkg::WIDTH_W-1:0]       glyph_width,
  output logic                              unmapped,
  output logic [gcs_pkg::COUNT_W-1:0]       glyph_total,
  output logic                              count_mismatch,
  output logic                              last
);
  import gcs_pkg::*;

  result_slot_t push0;
  result_slot_t push1;
  logic         room;
  result_t      head;

  gcs_profile #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_profile (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .alpha      (alpha),
    .column_end (column_end),
    .image_end  (image_end),
    .room       (room),
    .push0      (push0),
    .push1      (push1)
  );

  gcs_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push0     (push0),
    .push1     (push1),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign kind           = head.kind;
  assign glyph_ordinal  = head.glyph_ordinal;
  assign start_column   = head.start_column;
  assign glyph_width    = head.glyph_width;
  assign unmapped       = head.unmapped;
  assign glyph_total    = head.glyph_total;
  assign count_mismatch = head.count_mismatch;
  assign last           = head.last;

endmodule

/* hdl/gcs_profile.sv */
// Column profile and run tracking: input register, ink detect, glyph runs,
// result formation. Depends on gcs_pkg.
`timescale 1ns / 1ps

module gcs_profile #(
  parameter int MAX_COLUMNS = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [gcs_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [gcs_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [gcs_pkg::ALPHA_W-1:0]           alpha,
  input  logic                                  column_end,
  input  logic                                  image_end,
  input  logic                                  room,
  output gcs_pkg::result_slot_t                 push0,
  output gcs_pkg::result_slot_t                 push1
);
  import gcs_pkg::*;

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int WW = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;
  localparam logic [CW-1:0] COL_LAST = CW'(MAX_COLUMNS - 1);

  logic [ALPHA_W-1:0]  ink_level;
  logic [EXPECT_W-1:0] expected_glyphs;

  logic               pix_valid;
  logic [ALPHA_W-1:0] pix_alpha;
  logic               pix_column_end;
  logic               pix_image_end;

  logic [CW-1:0]      column_index;
  logic               column_inked;
  logic               glyph_open;
  logic [CW-1:0]      glyph_start;
  logic [COUNT_W-1:0] glyph_count;

  logic               advance;
  logic               inked_now;
  logic               col_done;
  logic               emit_close;
  logic               emit_final;
  logic               emit_glyph;
  logic [CW-1:0]      start_now;
  logic [WW-1:0]      width_wide;
  logic [WW-1:0]      start_wide;
  logic [COUNT_W-1:0] count_after;
  logic [COUNT_W-1:0] expected_wide;
  result_t            glyph_res;
  result_t            summary_res;

  logic               column_inked_next;
  logic               glyph_open_next;
  logic [CW-1:0]      glyph_start_next;
  logic [COUNT_W-1:0] glyph_count_next;
  logic [CW-1:0]      column_index_next;

  assign advance  = pix_valid & room;
  assign in_ready = ~pix_valid | room;

  always_ff @(posedge clk) begin
    if (rst) begin
      ink_level       <= '0;
      expected_glyphs <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INK_LEVEL:       ink_level       <= cfg_data[ALPHA_W-1:0];
        REG_EXPECTED_GLYPHS: expected_glyphs <= cfg_data[EXPECT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (in_ready) begin
      pix_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pix_alpha      <= alpha;
      pix_column_end <= column_end;
      pix_image_end  <= image_end;
    end
  end

  always_comb begin
    inked_now     = column_inked | (pix_alpha > ink_level);
    col_done      = pix_column_end | pix_image_end;
    emit_close    = col_done & ~inked_now & glyph_open;
    start_now     = (inked_now && !glyph_open) ? column_index : glyph_start;
    emit_final    = col_done & pix_image_end & inked_now;
    emit_glyph    = emit_close | emit_final;
    expected_wide = COUNT_W'(expected_glyphs);
    width_wide    = WW'(column_index) + WW'(emit_final) - WW'(start_now);
    start_wide    = WW'(start_now);
    count_after   = (emit_glyph && glyph_count != COUNT_MAX) ?
                    glyph_count + COUNT_W'(1) : glyph_count;

    glyph_res                = '0;
    glyph_res.kind           = KIND_GLYPH;
    glyph_res.glyph_ordinal  = (glyph_count > COUNT_W'(ORDINAL_MAX)) ?
                               ORDINAL_MAX : glyph_count[ORDINAL_W-1:0];
    glyph_res.start_column   = start_wide[START_W-1:0];
    glyph_res.glyph_width    = width_wide[WIDTH_W-1:0];
    glyph_res.unmapped       = (glyph_count >= expected_wide);
    glyph_res.last           = ~pix_image_end;

    summary_res                = '0;
    summary_res.kind           = KIND_SUMMARY;
    summary_res.glyph_total    = count_after;
    summary_res.count_mismatch = (count_after != expected_wide);
    summary_res.last           = 1'b1;

    push0 = '0;
    push1 = '0;
    if (advance && col_done) begin
      if (emit_glyph) begin
        push0.valid = 1'b1;
        push0.res   = glyph_res;
        push1.valid = pix_image_end;
        push1.res   = summary_res;
      end else begin
        push0.valid = pix_image_end;
        push0.res   = summary_res;
      end
    end

    column_inked_next = inked_now;
    glyph_open_next   = glyph_open;
    glyph_start_next  = glyph_start;
    glyph_count_next  = glyph_count;
    column_index_next = column_index;
    if (col_done) begin
      column_inked_next = 1'b0;
      if (pix_image_end) begin
        glyph_open_next   = 1'b0;
        glyph_start_next  = '0;
        glyph_count_next  = '0;
        column_index_next = '0;
      end else begin
        glyph_open_next   = inked_now;
        glyph_start_next  = start_now;
        glyph_count_next  = count_after;
        if (column_index < COL_LAST) begin
          column_index_next = column_index + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      column_inked <= 1'b0;
      glyph_open   <= 1'b0;
      glyph_start  <= '0;
      glyph_count  <= '0;
    end else if (advance) begin
      column_index <= column_index_next;
      column_inked <= column_inked_next;
      glyph_open   <= glyph_open_next;
      glyph_start  <= glyph_start_next;
      glyph_count  <= glyph_count_next;
    end
  end

endmodule

/* hdl/gcs_result_fifo.sv */
// Four-entry result queue: up to two pushes and one pop per cycle.
// Depends on gcs_pkg.
`timescale 1ns / 1ps

module gcs_result_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  gcs_pkg::result_slot_t push0,
  input  gcs_pkg::result_slot_t push1,
  output logic                  room,
  output logic                  out_valid,
  input  logic                  out_ready,
  output gcs_pkg::result_t      head
);
  import gcs_pkg::*;

  result_t    mem [4];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [2:0] count;
  logic       pop;
  logic [2:0] count_next;

  assign out_valid = (count != 3'd0);
  assign room      = (count <= 3'd2);
  assign pop       = out_valid & out_ready;
  assign head      = mem[rptr];

  always_comb begin
    count_next = count + 3'(push0.valid) + 3'(push1.valid) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (push0.valid) begin
      mem[wptr] <= push0.res;
    end
    if (push1.valid) begin
      mem[wptr + 2'd1] <= push1.res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + 2'(push0.valid) + 2'(push1.valid);
      rptr  <= rptr + 2'(pop);
      count <= count_next;
    end
  end

endmodule

/* tb/sv/glyph_segment_checker.sv */
// Glyph segment checker: watches the config port and both channels of the
// glyph column segmenter, predicts each result and compares the whole record.
// Depends on gcs_pkg.
`timescale 1ns / 1ps

module glyph_segment_checker #(
  parameter int MAX_COLUMNS = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [gcs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gcs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [gcs_pkg::ALPHA_W-1:0]     alpha,
  input  logic                            column_end,
  input  logic                            image_end,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            kind,
  input  logic [gcs_pkg::ORDINAL_W-1:0]   glyph_ordinal,
  input  logic [gcs_pkg::START_W-1:0]     start_column,
  input  logic [gcs_pkg::WIDTH_W-1:0]     glyph_width,
  input  logic                            unmapped,
  input  logic [gcs_pkg::COUNT_W-1:0]     glyph_total,
  input  logic                            count_mismatch,
  input  logic                            last,
  output int                              fail_count,
  output int                              results_pending
);

  import gcs_pkg::*;

  localparam logic [START_W-1:0] COLUMN_LAST = START_W'(MAX_COLUMNS - 1);

  logic [ALPHA_W-1:0]  threshold_reg;
  logic [EXPECT_W-1:0] glyphs_expected_reg;

  logic [START_W-1:0]  column_index;
  logic                column_inked;
  logic                run_open;
  logic [START_W-1:0]  run_start;
  logic [COUNT_W-1:0]  glyph_count;

  result_t glyph_results_due[$];
  int      reported;

  initial begin
    fail_count      = 0;
    results_pending = 0;
    reported        = 0;
  end

  function automatic string show(input result_t r);
    return $sformatf({"kind=%0d ord=%0d start=%0d width=%0d unmapped=%0d",
                      " total=%0d mm=%0d last=%0d"},
                     r.kind, r.glyph_ordinal, r.start_column, r.glyph_width, r.unmapped,
                     r.glyph_total, r.count_mismatch, r.last);
  endfunction

  function automatic result_t close_glyph(input logic [WIDTH_W-1:0] span);
    result_t r;
    r = '0;
    r.kind = KIND_GLYPH;
    r.glyph_ordinal = (glyph_count > COUNT_W'(ORDINAL_MAX)) ? ORDINAL_MAX
                                                            : glyph_count[ORDINAL_W-1:0];
    r.start_column = run_start;
    r.glyph_width = span;
    r.unmapped = (glyph_count >= COUNT_W'(glyphs_expected_reg));
    if (glyph_count != COUNT_MAX) glyph_count = glyph_count + 1'b1;
    run_open = 1'b0;
    return r;
  endfunction

  task automatic segment_pixel(input logic [ALPHA_W-1:0] a, input logic col_done,
                               input logic img_done);
    result_t outs[2];
    result_t r;
    int n;
    n = 0;
    if (a > threshold_reg) column_inked = 1'b1;
    if (col_done || img_done) begin
      if (column_inked) begin
        if (!run_open) begin
          run_open  = 1'b1;
          run_start = column_index;
        end
      end else if (run_open) begin
        outs[n] = close_glyph(WIDTH_W'(column_index) - WIDTH_W'(run_start));
        n++;
      end
      column_inked = 1'b0;
      if (img_done) begin
        if (run_open) begin
          outs[n] = close_glyph(WIDTH_W'(column_index) + 1'b1 - WIDTH_W'(run_start));
          n++;
        end
        r = '0;
        r.kind = KIND_SUMMARY;
        r.glyph_total = glyph_count;
        r.count_mismatch = (glyph_count != COUNT_W'(glyphs_expected_reg));
        outs[n] = r;
        n++;
        column_index = '0;
        run_open     = 1'b0;
        run_start    = '0;
        glyph_count  = '0;
      end else if (column_index != COLUMN_LAST) begin
        column_index = column_index + 1'b1;
      end
      for (int i = 0; i < n; i++) begin
        r = outs[i];
        r.last = (i == n - 1);
        glyph_results_due.push_back(r);
      end
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      threshold_reg       = '0;
      glyphs_expected_reg = '0;
      column_index        = '0;
      column_inked        = 1'b0;
      run_open            = 1'b0;
      run_start           = '0;
      glyph_count         = '0;
      glyph_results_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_INK_LEVEL) threshold_reg = cfg_data[ALPHA_W-1:0];
        else if (cfg_index == REG_EXPECTED_GLYPHS) glyphs_expected_reg = cfg_data;
      end
      if (in_valid && in_ready) segment_pixel(alpha, column_end, image_end);
      if (out_valid && out_ready) begin
        got = {kind, glyph_ordinal, start_column, glyph_width, unmapped, glyph_total,
               count_mismatch, last};
        if (glyph_results_due.size() == 0) begin
          fail_count++;
          if (reported < 10) begin
            reported++;
            $display("%0t: unexpected result: %s", $realtime, show(got));
          end
        end else begin
          want = glyph_results_due.pop_front();
          if (got !== want) begin
            fail_count++;
            if (reported < 10) begin
              reported++;
              $display("%0t: result mismatch", $realtime);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
          end
        end
      end
    end
    results_pending = glyph_results_due.size();
  end

endmodule

/* tb/sv/tb_top.sv */
// Testbench top for glyph_column_segmenter_unit: clock, reset, config writes,
// pixel stimulus and result back-pressure. Depends on gcs_pkg and glyph_segment_checker.
`timescale 1ns / 1ps

module tb_top;

  import gcs_pkg::*;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [ALPHA_W-1:0]     alpha = '0;
  logic                   column_end = 1'b0;
  logic                   image_end = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   kind;
  logic [ORDINAL_W-1:0]   glyph_ordinal;
  logic [START_W-1:0]     start_column;
  logic [WIDTH_W-1:0]     glyph_width;
  logic                   unmapped;
  logic [COUNT_W-1:0]     glyph_total;
  logic                   count_mismatch;
  logic                   last;

  int fail_count;
  int results_pending;

  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  logic        hold_start = 1'b0;
  int          hold_left = 0;
  int          pixels_sent = 0;
  logic [7:0]  cur_threshold = '0;

  glyph_column_segmenter_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .alpha(alpha), .column_end(column_end), .image_end(image_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .glyph_ordinal(glyph_ordinal), .start_column(start_column),
    .glyph_width(glyph_width), .unmapped(unmapped), .glyph_total(glyph_total),
    .count_mismatch(count_mismatch), .last(last)
  );

  glyph_segment_checker checker_i (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .alpha(alpha), .column_end(column_end), .image_end(image_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .glyph_ordinal(glyph_ordinal), .start_column(start_column),
    .glyph_width(glyph_width), .unmapped(unmapped), .glyph_total(glyph_total),
    .count_mismatch(count_mismatch), .last(last),
    .fail_count(fail_count), .results_pending(results_pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // hold off the receiver for a counted stretch when asked
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_start) begin
      hold_left = 300;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  task automatic set_idling(input int mode);
    case (mode)
      0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      1: begin sender_idle_pct = 64; receiver_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct = 64; end
      default: begin sender_idle_pct = 8; receiver_stall_pct = 8; end
    endcase
  endtask

  task automatic set_config(input logic [7:0] thr, input logic [8:0] glyphs_due);
    cfg_we    <= 1'b1;
    cfg_index <= REG_INK_LEVEL;
    cfg_data  <= CFG_DATA_W'(thr);
    @(posedge clk);
    cfg_index <= REG_EXPECTED_GLYPHS;
    cfg_data  <= glyphs_due;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_threshold = thr;
  endtask

  task automatic send_pixel(input logic [7:0] a, input logic ce, input logic ie);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    alpha      <= a;
    column_end <= ce;
    image_end  <= ie;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_alpha(input logic ink);
    if (ink && cur_threshold != 8'd255)
      return 8'($urandom_range(255, int'(cur_threshold) + 1));
    return 8'($urandom_range(int'(cur_threshold), 0));
  endfunction

  task automatic send_random_image();
    int n_cols;
    int h;
    int k;
    logic inked;
    logic bottom;
    logic last_px;
    logic ce;
    logic [7:0] a;
    if ($urandom_range(0, 9) == 0) begin
      // noise: arbitrary flags and alpha
      n_cols = $urandom_range(1, 12);
      for (int p = 0; p < n_cols; p++)
        send_pixel(8'($urandom), 1'($urandom_range(0, 1)),
                   (p == n_cols - 1) || ($urandom_range(0, 15) == 0));
    end else begin
      n_cols = $urandom_range(1, 14);
      inked = 1'($urandom_range(0, 1));
      for (int c = 0; c < n_cols; c++) begin
        if ($urandom_range(0, 99) < 35) inked = !inked;
        h = $urandom_range(1, 4);
        k = $urandom_range(0, h - 1);
        for (int p = 0; p < h; p++) begin
          bottom  = (p == h - 1);
          last_px = bottom && (c == n_cols - 1);
          ce = bottom && !(last_px && $urandom_range(0, 3) == 0);
          if ($urandom_range(0, 9) == 0) a = 8'($urandom);
          else a = pick_alpha(inked && p == k);
          send_pixel(a, ce, last_px);
        end
      end
    end
  endtask

  // one-pixel columns; every other column inked from ink_from on
  task automatic send_stripes(input int n_cols, input int ink_from, input int parity);
    for (int c = 0; c < n_cols; c++)
      send_pixel(pick_alpha(c >= ink_from && (c % 2) == parity), 1'b1, c == n_cols - 1);
  endtask

  initial begin
    int start_count;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    set_idling(0);
    set_config(8'd0, 9'd1);
    send_pixel(8'd0,   1'b1, 1'b1);
    send_pixel(8'd255, 1'b0, 1'b1);
    send_pixel(8'd0,   1'b0, 1'b0);
    send_pixel(8'd1,   1'b1, 1'b0);
    send_pixel(8'd0,   1'b1, 1'b0);
    send_pixel(8'd0,   1'b0, 1'b0);
    send_pixel(8'd128, 1'b1, 1'b0);
    send_pixel(8'd255, 1'b1, 1'b0);
    send_pixel(8'd0,   1'b1, 1'b0);
    send_pixel(8'd0,   1'b1, 1'b1);
    send_pixel(8'd200, 1'b1, 1'b0);
    send_pixel(8'd0,   1'b1, 1'b0);
    send_pixel(8'd7,   1'b1, 1'b1);
    send_pixel(8'd9,   1'b1, 1'b0);
    send_pixel(8'd0,   1'b1, 1'b1);
    send_pixel(8'd85,  1'b0, 1'b0);
    send_pixel(8'd170, 1'b0, 1'b1);
    drain_results();

    for (int ph = 0; ph < 8; ph++) begin
      set_idling(ph % 4);
      case (ph)
        0: set_config(8'd0, 9'd0);
        1: set_config(8'd255, 9'd511);
        2: set_config(8'd128, 9'd256);
        3: set_config(8'd1, 9'd3);
        4: set_config(8'd254, 9'd1);
        default: set_config(8'($urandom), 9'($urandom_range(0, 6)));
      endcase
      start_count = pixels_sent;
      while (pixels_sent - start_count < 30) send_random_image();
      // in phase 2, pause until the block has emptied
      if (ph == 2) drain_results();
      while (pixels_sent - start_count < 60) send_random_image();
      drain_results();
    end

    // long receiver hold-off while pixels keep coming
    set_idling(0);
    set_config(8'd100, 9'd2);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    start_count = pixels_sent;
    while (pixels_sent - start_count < 150) send_random_image();
    drain_results();

    // column index saturation, run opening at the last index
    set_idling(3);
    set_config(8'd100, 9'd3);
    send_stripes(1100, 1020, 1);
    drain_results();

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(4_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule
